// ===== hdl/csam_pkg.sv =====
// ----------------------------------------------------------------------------
// csam_pkg
// Shared widths, reset values and register codes for the current sense
// average / median block.
// ----------------------------------------------------------------------------
`default_nettype none

package csam_pkg;

  localparam int RING_DEPTH_DEF  = 5;
  localparam int SAMPLE_BITS_DEF = 12;

  localparam int GAIN_W  = 18;
  localparam int OFS_W   = 29;
  localparam int CUR_W   = 13;
  localparam int AVG_W   = 12;
  localparam int CNT_W   = 8;
  localparam int SUM_W   = 22;
  localparam int DVD_W   = SUM_W - 1;
  localparam int CFG_W   = 29;
  localparam int CFG_IDX_W = 2;
  localparam int FRAC_W  = 16;

  localparam logic [GAIN_W-1:0]       GAIN_RST  = 18'd78683;
  localparam logic signed [OFS_W-1:0] OFS_RST   = -29'sd159082086;
  localparam logic signed [CUR_W-1:0] LIMIT_RST = 13'sd1500;
  localparam logic [CNT_W-1:0]        COUNT_RST = 8'd50;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GAIN   = 2'd0,
    REG_OFFSET = 2'd1,
    REG_LIMIT  = 2'd2,
    REG_COUNT  = 2'd3
  } cfg_reg_t;

endpackage

`default_nettype wire

// ===== hdl/csam_div.sv =====
// ----------------------------------------------------------------------------
// csam_div
// Restoring divider, one quotient bit per cycle, for the window average.
// ----------------------------------------------------------------------------
`default_nettype none

module csam_div import csam_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic [DVD_W-1:0] dividend,
  input  wire logic [CNT_W-1:0] divisor,
  output logic                  done,
  output logic      [DVD_W-1:0] quotient
);

  localparam int STEP_W = $clog2(DVD_W);

  logic              busy_r;
  logic              done_r;
  logic [STEP_W-1:0] step_r;
  logic [CNT_W-1:0]  rem_r;
  logic [CNT_W-1:0]  dvs_r;
  logic [DVD_W-1:0]  q_r;
  logic [CNT_W:0]    trial;
  logic [CNT_W:0]    diff;
  logic              ge;

  always_comb begin
    trial = {rem_r, q_r[DVD_W-1]};
    ge    = (trial >= {1'b0, dvs_r});
    diff  = trial - {1'b0, dvs_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        step_r <= '0;
      end else if (busy_r) begin
        step_r <= step_r + 1'b1;
        if (step_r == STEP_W'(DVD_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      q_r   <= dividend;
      dvs_r <= divisor;
    end else if (busy_r) begin
      rem_r <= ge ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
      q_r   <= {q_r[DVD_W-2:0], ge};
    end
  end

  assign done     = done_r;
  assign quotient = q_r;

endmodule

`default_nettype wire

// ===== hdl/current_sense_average_median_unit.sv =====
// ----------------------------------------------------------------------------
// current_sense_average_median_unit
// Converts ADC samples to centiamps, flags overcurrent, averages windows of
// samples and reports the median of the last RING_DEPTH window averages.
//
// Usage:
//   Input channel in_valid / in_stall carries one ADC sample per transaction.
//   Output channel out_valid / out_stall returns exactly one result per
//   sample: instant current, overcurrent flag, window-closed flag, median.
//   Config port cfg_we / cfg_idx / cfg_data writes gain, offset, limit and
//   window length; write only while the block is idle.
//   A sample that does not close a window passes from acceptance to the next
//   acceptance through multiply, offset and saturate, accumulate, output and
//   idle; its result is registered in the output step. A closing sample
//   also passes through the one-bit-per-cycle divider, one ring write,
//   and the median search, which holds each candidate against every ring
//   entry with a less-than and a less-or-equal compare.
//   in_stall is high while a sample is in work. A finished result sits in
//   the output register; the next sample is accepted meanwhile, and its
//   result waits in the last step until out_stall lets the previous go.
//   Synchronous reset restores the register defaults and clears the window
//   sum, sample count, ring, ring pointer and median.
// ----------------------------------------------------------------------------
`default_nettype none

module current_sense_average_median_unit import csam_pkg::*; #(
  parameter int RING_DEPTH  = RING_DEPTH_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    in_valid,
  output logic                         in_stall,
  input  wire logic [SAMPLE_BITS-1:0]  in_adc_sample,
  output logic                         out_valid,
  input  wire logic                    out_stall,
  output logic signed [CUR_W-1:0]      out_instant_current,
  output logic                         out_overcurrent,
  output logic                         out_median_updated,
  output logic        [AVG_W-1:0]      out_median_current,
  input  wire logic                    cfg_we,
  input  wire logic [CFG_IDX_W-1:0]    cfg_idx,
  input  wire logic [CFG_W-1:0]        cfg_data
);

  localparam int PROD_W = SAMPLE_BITS + GAIN_W;
  localparam int ACC_W  = ((PROD_W > OFS_W) ? PROD_W : OFS_W) + 2;
  localparam int IDX_W  = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int RCNT_W = $clog2(RING_DEPTH + 1);
  localparam int MID    = RING_DEPTH / 2;

  typedef enum logic [9:0] {
    S_IDLE  = 10'b0000000001,
    S_MUL   = 10'b0000000010,
    S_CONV  = 10'b0000000100,
    S_SUM   = 10'b0000001000,
    S_DIV   = 10'b0000010000,
    S_WR    = 10'b0000100000,
    S_LOAD  = 10'b0001000000,
    S_SCAN  = 10'b0010000000,
    S_CHECK = 10'b0100000000,
    S_OUT   = 10'b1000000000
  } state_t;

  state_t state_r, state_nxt;

  logic        [GAIN_W-1:0] gain_r;
  logic signed [OFS_W-1:0]  ofs_r;
  logic signed [CUR_W-1:0]  limit_r;
  logic        [CNT_W-1:0]  count_r;

  logic [SAMPLE_BITS-1:0]   adc_r;
  logic [PROD_W-1:0]        prod_r;
  logic signed [CUR_W-1:0]  cur_r;
  logic                     ovc_r;
  logic                     upd_r;
  logic signed [SUM_W-1:0]  sum_r;
  logic [CNT_W-1:0]         cnt_r;
  logic [AVG_W-1:0]         ring_r [RING_DEPTH];
  logic [IDX_W-1:0]         widx_r;
  logic [IDX_W-1:0]         i_r;
  logic [IDX_W-1:0]         j_r;
  logic [AVG_W-1:0]         cand_r;
  logic [RCNT_W-1:0]        lt_r;
  logic [RCNT_W-1:0]        le_r;
  logic [AVG_W-1:0]         median_r;

  logic                     out_valid_r;
  logic signed [CUR_W-1:0]  out_cur_r;
  logic                     out_ovc_r;
  logic                     out_upd_r;
  logic [AVG_W-1:0]         out_med_r;

  logic signed [ACC_W-1:0]  acc;
  logic signed [ACC_W-1:0]  shifted;
  logic signed [CUR_W-1:0]  cur_sat;
  logic signed [SUM_W-1:0]  sum_nxt;
  logic [CNT_W-1:0]         cnt_nxt;
  logic [CNT_W-1:0]         limit_cnt;
  logic                     close;
  logic [DVD_W-1:0]         dvd;
  logic [CNT_W-1:0]         dvs;
  logic [DVD_W-1:0]         quotient;
  logic [AVG_W-1:0]         avg;
  logic [IDX_W-1:0]         rd_idx;
  logic [AVG_W-1:0]         rd_val;
  logic                     out_free;
  logic                     div_start;
  logic                     div_done;

  // Conversion: product plus offset, floor shift, saturate to 13 bits
  always_comb begin
    acc     = $signed({{(ACC_W-PROD_W){1'b0}}, prod_r})
            + {{(ACC_W-OFS_W){ofs_r[OFS_W-1]}}, ofs_r};
    shifted = acc >>> FRAC_W;
    if (!shifted[ACC_W-1] && (|shifted[ACC_W-1:CUR_W-1])) begin
      cur_sat = {1'b0, {(CUR_W-1){1'b1}}};
    end else if (shifted[ACC_W-1] && !(&shifted[ACC_W-1:CUR_W-1])) begin
      cur_sat = {1'b1, {(CUR_W-1){1'b0}}};
    end else begin
      cur_sat = shifted[CUR_W-1:0];
    end
  end

  always_comb begin
    sum_nxt   = sum_r + {{(SUM_W-CUR_W){cur_r[CUR_W-1]}}, cur_r};
    cnt_nxt   = cnt_r + 1'b1;
    limit_cnt = (count_r == '0) ? CNT_W'(1) : count_r;
    close     = (cnt_nxt >= limit_cnt);
    dvd       = (!sum_nxt[SUM_W-1] && (|sum_nxt)) ? sum_nxt[DVD_W-1:0] : '0;
    dvs       = cnt_nxt;
    avg       = (|quotient[DVD_W-1:AVG_W]) ? {AVG_W{1'b1}} : quotient[AVG_W-1:0];
    rd_idx    = (state_r == S_LOAD) ? i_r : j_r;
    rd_val    = ring_r[rd_idx];
    out_free  = !out_valid_r || !out_stall;
  end

  assign div_start = (state_r == S_SUM) && close;

  csam_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (dvd),
    .divisor  (dvs),
    .done     (div_done),
    .quotient (quotient)
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (in_valid) state_nxt = S_MUL;
      S_MUL:   state_nxt = S_CONV;
      S_CONV:  state_nxt = S_SUM;
      S_SUM:   state_nxt = close ? S_DIV : S_OUT;
      S_DIV:   if (div_done) state_nxt = S_WR;
      S_WR:    state_nxt = S_LOAD;
      S_LOAD:  state_nxt = S_SCAN;
      S_SCAN:  if (j_r == IDX_W'(RING_DEPTH - 1)) state_nxt = S_CHECK;
      S_CHECK: begin
        if ((lt_r <= RCNT_W'(MID)) && (le_r > RCNT_W'(MID))) state_nxt = S_OUT;
        else state_nxt = S_LOAD;
      end
      S_OUT:   if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // Control state, config registers and persistent window/ring state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      gain_r      <= GAIN_RST;
      ofs_r       <= OFS_RST;
      limit_r     <= LIMIT_RST;
      count_r     <= COUNT_RST;
      sum_r       <= '0;
      cnt_r       <= '0;
      widx_r      <= '0;
      median_r    <= '0;
      out_valid_r <= 1'b0;
      for (int k = 0; k < RING_DEPTH; k++) begin
        ring_r[k] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        unique case (cfg_reg_t'(cfg_idx))
          REG_GAIN:   gain_r  <= cfg_data[GAIN_W-1:0];
          REG_OFFSET: ofs_r   <= cfg_data[OFS_W-1:0];
          REG_LIMIT:  limit_r <= cfg_data[CUR_W-1:0];
          REG_COUNT:  count_r <= cfg_data[CNT_W-1:0];
          default:    ;
        endcase
      end
      if (state_r == S_SUM) begin
        if (close) begin
          sum_r <= '0;
          cnt_r <= '0;
        end else begin
          sum_r <= sum_nxt;
          cnt_r <= cnt_nxt;
        end
      end
      if (state_r == S_WR) begin
        ring_r[widx_r] <= avg;
        widx_r <= (widx_r == IDX_W'(RING_DEPTH - 1)) ? '0 : widx_r + 1'b1;
      end
      if ((state_r == S_CHECK) && (lt_r <= RCNT_W'(MID)) && (le_r > RCNT_W'(MID))) begin
        median_r <= cand_r;
      end
      if ((state_r == S_OUT) && out_free) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if ((state_r == S_IDLE) && in_valid) begin
      adc_r <= in_adc_sample;
    end
    if (state_r == S_MUL) begin
      prod_r <= adc_r * gain_r;
    end
    if (state_r == S_CONV) begin
      cur_r <= cur_sat;
    end
    if (state_r == S_SUM) begin
      ovc_r <= (cur_r > limit_r);
      upd_r <= close;
    end
    if (state_r == S_WR) begin
      i_r <= '0;
    end
    if (state_r == S_LOAD) begin
      cand_r <= rd_val;
      lt_r   <= '0;
      le_r   <= '0;
      j_r    <= '0;
    end
    if (state_r == S_SCAN) begin
      lt_r <= lt_r + RCNT_W'(rd_val < cand_r);
      le_r <= le_r + RCNT_W'(rd_val <= cand_r);
      j_r  <= j_r + 1'b1;
    end
    if (state_r == S_CHECK) begin
      i_r <= i_r + 1'b1;
    end
    if ((state_r == S_OUT) && out_free) begin
      out_cur_r <= cur_r;
      out_ovc_r <= ovc_r;
      out_upd_r <= upd_r;
      out_med_r <= median_r;
    end
  end

  assign in_stall            = (state_r != S_IDLE);
  assign out_valid           = out_valid_r;
  assign out_instant_current = out_cur_r;
  assign out_overcurrent     = out_ovc_r;
  assign out_median_updated  = out_upd_r;
  assign out_median_current  = out_med_r;

endmodule

`default_nettype wire
